// ===== hw/rtl/substring_search_first_match_core_assert.svh =====
// Assertion macros for the substring search core.
`ifndef SUBSTRING_SEARCH_FIRST_MATCH_CORE_ASSERT_SVH
`define SUBSTRING_SEARCH_FIRST_MATCH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSFM_ASSERT_IMP(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define SSFM_ASSERT_NXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSFM_ASSERT_IMP(label, clock, rstn, ante, cons, msg)
`define SSFM_ASSERT_NXT(label, clock, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/ssfm_pkg.sv =====
// Package with constants and types for the substring search core.
package ssfm_pkg;
	localparam int MAX_NEEDLE = 32;
	localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
	localparam int POS_W = $clog2(MAX_NEEDLE);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int COUNT_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd4;

	typedef logic [7:0] byte_t;
	typedef logic [COUNT_W-1:0] count_t;
endpackage

// ===== hw/rtl/substring_search_first_match_core.sv =====
// Top level of the substring search core: finds the first needle occurrence in a stream.
//
// Use: write the needle bytes (registers 0 to 3) and the needle length (register 4)
// through the cfg_we/cfg_index/cfg_data port while no haystack is in flight.
// Haystack bytes arrive as requests on the s_ channel, one byte per request, with
// s_tlast set on the last byte of a haystack. Each byte is compared against the
// whole needle at once over a 32-byte sliding window.
// On the last byte one request leaves on the m_ channel: m_tuser is the found
// flag and m_tdata the start index of the first occurrence (0 if not found).
// Throughput is one byte per cycle while s_tready is high. A byte is registered
// in the input stage, and the result is registered once its last byte leaves that stage.
// The result register and the input stage are separate, so bytes that do not
// end a haystack keep flowing while a result waits; s_tready drops only when a
// last byte in the input stage finds the result register still full.
// Reset clears the window, the byte count, the match record and both valid
// flags; the needle resets to length 1 with all bytes zero.
module substring_search_first_match_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,    // haystack_byte
	input  logic                           s_tlast,    // is_final
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,    // match_position
	output logic                           m_tuser,    // match_found
	input  logic                           cfg_we,
	input  logic [ssfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssfm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ssfm_pkg::*;

	`include "substring_search_first_match_core_assert.svh"

	logic [MAX_NEEDLE*8-1:0] needle_q;
	logic [LEN_W-1:0]        length_q;

	logic                    valid_s1;
	byte_t                   byte_s1;
	logic                    last_s1;

	byte_t                   win_q [MAX_NEEDLE];
	byte_t                   win_next [MAX_NEEDLE];
	count_t                  bytes_seen_q;
	count_t                  seen_next;
	logic                    have_match_q;
	count_t                  first_idx_q;

	logic                    out_valid_q;
	logic                    out_found_q;
	count_t                  out_pos_q;

	logic [LEN_W-1:0]        used_len;
	logic                    advance;
	logic                    equal;
	logic                    hit;
	logic                    match_next;
	count_t                  idx_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q <= '0;
			length_q <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEEDLE_0: needle_q[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_NEEDLE_1: needle_q[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_NEEDLE_2: needle_q[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_NEEDLE_3: needle_q[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_LENGTH:   length_q <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (length_q == '0) begin
			used_len = LEN_W'(1);
		end else if (length_q > LEN_W'(MAX_NEEDLE)) begin
			used_len = LEN_W'(MAX_NEEDLE);
		end else begin
			used_len = length_q;
		end
	end

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// The needle byte aligned with window entry j is byte used_len-1-j.
	always_comb begin
		logic [LEN_W-1:0] sel;
		logic             lane_ok;
		win_next[0] = byte_s1;
		for (int j = 1; j < MAX_NEEDLE; j++) begin
			win_next[j] = win_q[j-1];
		end
		equal = 1'b1;
		for (int j = 0; j < MAX_NEEDLE; j++) begin
			sel     = used_len - LEN_W'(1) - LEN_W'(j);
			lane_ok = (win_next[j] == needle_q[sel[POS_W-1:0]*8 +: 8]);
			if (LEN_W'(j) < used_len && !lane_ok) begin
				equal = 1'b0;
			end
		end
	end

	always_comb begin
		seen_next  = (bytes_seen_q == '1) ? bytes_seen_q : bytes_seen_q + COUNT_W'(1);
		hit        = !have_match_q && (seen_next >= COUNT_W'(used_len)) && equal;
		match_next = have_match_q || hit;
		idx_next   = hit ? (seen_next - COUNT_W'(used_len)) : first_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_NEEDLE; j++) begin
				win_q[j] <= '0;
			end
			bytes_seen_q <= '0;
			have_match_q <= 1'b0;
			first_idx_q  <= '0;
		end else if (advance) begin
			if (last_s1) begin
				for (int j = 0; j < MAX_NEEDLE; j++) begin
					win_q[j] <= '0;
				end
				bytes_seen_q <= '0;
				have_match_q <= 1'b0;
				first_idx_q  <= '0;
			end else begin
				for (int j = 0; j < MAX_NEEDLE; j++) begin
					win_q[j] <= win_next[j];
				end
				bytes_seen_q <= seen_next;
				have_match_q <= match_next;
				first_idx_q  <= idx_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_found_q <= match_next;
			out_pos_q   <= match_next ? idx_next : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = out_pos_q;

	`SSFM_ASSERT_IMP(a_pos_zero_when_absent, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0, "position must be zero when no match")
	`SSFM_ASSERT_NXT(a_last_gives_result, clk, arst_n, advance && last_s1, m_tvalid, "last byte did not produce a result")
	`SSFM_ASSERT_NXT(a_clear_after_last, clk, arst_n, advance && last_s1, bytes_seen_q == '0 && !have_match_q, "state not cleared after last byte")
	`SSFM_ASSERT_IMP(a_stall_holds_last, clk, arst_n, valid_s1 && last_s1 && out_valid_q && !m_tready, !s_tready, "input stage overwritten while result pending")
endmodule
